@@ hdl/mining_nonce_verifier_macros.svh @@
// Assertion macros shared by the verifier modules.
`ifndef MINING_NONCE_VERIFIER_MACROS_SVH
`define MINING_NONCE_VERIFIER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MNV_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition.
`define MNV_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/mnv_pkg.sv @@
package mnv_pkg;

  typedef struct packed {
    logic [31:0] raw_nonce;
    logic        batch_start;
  } in_req_t;

  typedef struct packed {
    logic        nonce_valid;
    logic [31:0] nonce_value;
    logic [2:0]  offset_choice;
  } out_req_t;

  // Request handed from the front part to the hash engine.
  typedef struct packed {
    logic [31:0] decoded;
  } job_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_READ,
    FR_CMP,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD1,
    BK_ROUND,
    BK_FIN,
    BK_DONE,
    BK_OUT
  } back_state_t;

  localparam logic [3:0] REG_MID01 = 4'd0;
  localparam logic [3:0] REG_MID23 = 4'd1;
  localparam logic [3:0] REG_MID45 = 4'd2;
  localparam logic [3:0] REG_MID67 = 4'd3;
  localparam logic [3:0] REG_MERKLE = 4'd4;
  localparam logic [3:0] REG_TIME = 4'd5;
  localparam logic [3:0] REG_BITS = 4'd6;

  localparam logic [31:0] DECODE_BIAS = 32'h0080_0004;
  localparam int NUM_TRIALS = 6;

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] IV_STD = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] TRIAL_OFFSET [NUM_TRIALS] = '{
    32'h0000_0000, 32'hFFC0_0000, 32'hFF80_0000,
    32'h0280_0000, 32'h02C0_0000, 32'h0040_0000
  };

  function automatic logic [31:0] decode_nonce(input logic [31:0] raw);
    logic [23:0] v;
    logic [31:0] o;
    for (int b = 0; b < 3; b++) begin
      for (int i = 0; i < 8; i++) begin
        v[b*8+i] = raw[8+b*8+7-i];
      end
    end
    o = {raw[7:0], v[0], v[1], v[23:2]};
    return o - DECODE_BIAS;
  endfunction

endpackage

@@ hdl/mining_nonce_verifier.sv @@
// Channel   Direction  Payload              Handshake
// req       in         in_req_t             req_valid / req_stall
// res       out        out_req_t            res_valid / res_stall
// cfg       in         index, 64-bit data   cfg_we
//
// A request first passes the front, which scans the seen store (a read state and a
// compare state per stored nonce, plus accept and push), then up to six offset trials
// in the hash engine, which runs one SHA-256 round per cycle.
// Reset is synchronous and clears the control state, the seen count, the queue and
// the configuration registers.
// A stalled result holds the hash engine, while the front keeps screening the next
// request into the two-entry queue between them.
module mining_nonce_verifier #(
  parameter int SEEN_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mnv_pkg::in_req_t  req,
  output logic              res_valid,
  input  logic              res_stall,
  output mnv_pkg::out_req_t res,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  logic [255:0] midstate;
  logic [95:0] tail;
  logic push, full, pop_valid, pop;
  mnv_pkg::job_t push_data, pop_data;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      midstate <= '0;
      tail <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mnv_pkg::REG_MID01: midstate[255:192] <= cfg_data;
        mnv_pkg::REG_MID23: midstate[191:128] <= cfg_data;
        mnv_pkg::REG_MID45: midstate[127:64] <= cfg_data;
        mnv_pkg::REG_MID67: midstate[63:0] <= cfg_data;
        mnv_pkg::REG_MERKLE: tail[95:64] <= cfg_data[31:0];
        mnv_pkg::REG_TIME: tail[63:32] <= cfg_data[31:0];
        mnv_pkg::REG_BITS: tail[31:0] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  mnv_front #(.SEEN_DEPTH(SEEN_DEPTH)) u_front (
    .clk, .rst, .req_valid, .req_stall, .req,
    .job_valid(push), .job_full(full), .job(push_data)
  );

  mnv_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop_valid, .pop, .pop_data
  );

  mnv_hash u_hash (
    .clk, .rst, .job_valid(pop_valid), .job_pop(pop), .job(pop_data),
    .midstate, .tail, .res_valid, .res_stall, .res
  );

endmodule

@@ hdl/mnv_front.sv @@
`include "mining_nonce_verifier_macros.svh"

module mnv_front #(
  parameter int SEEN_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  mnv_pkg::in_req_t req,
  output logic             job_valid,
  input  logic             job_full,
  output mnv_pkg::job_t    job
);

  localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CW = $clog2(SEEN_DEPTH + 1);

  logic [31:0] mem [SEEN_DEPTH];
  logic [31:0] rd_data;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [31:0] raw, raw_next;
  logic wr_en;
  mnv_pkg::front_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnv_pkg::FR_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx <= idx_next;
    raw <= raw_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= raw;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    raw_next = raw;
    wr_en = 1'b0;
    req_stall = 1'b1;
    job_valid = 1'b0;
    job.decoded = mnv_pkg::decode_nonce(raw);
    unique case (state)
      mnv_pkg::FR_IDLE: begin
        req_stall = 1'b0;
        idx_next = '0;
        if (req_valid) begin
          raw_next = req.raw_nonce;
          if (req.batch_start) count_next = '0;
          state_next = mnv_pkg::FR_READ;
        end
      end
      mnv_pkg::FR_READ: begin
        if (idx >= count) begin
          state_next = mnv_pkg::FR_PUSH;
        end else begin
          state_next = mnv_pkg::FR_CMP;
        end
      end
      mnv_pkg::FR_CMP: begin
        if (rd_data == raw) begin
          state_next = mnv_pkg::FR_IDLE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = mnv_pkg::FR_READ;
        end
      end
      mnv_pkg::FR_PUSH: begin
        if (!job_full) begin
          job_valid = 1'b1;
          if (count < CW'(SEEN_DEPTH)) begin
            wr_en = 1'b1;
            count_next = count + 1'b1;
          end
          state_next = mnv_pkg::FR_IDLE;
        end
      end
      default: state_next = mnv_pkg::FR_IDLE;
    endcase
  end

  `MNV_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(SEEN_DEPTH), "seen count overflow")
  `MNV_ASSERT_IMP(a_push_not_full, clk, rst, job_valid, !job_full, "push into full queue")
  `MNV_ASSERT_NEXT(a_take_read, clk, rst, state == mnv_pkg::FR_IDLE && req_valid,
                   state == mnv_pkg::FR_READ, "request not taken")

endmodule

@@ hdl/mnv_queue.sv @@
`include "mining_nonce_verifier_macros.svh"

module mnv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mnv_pkg::job_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output mnv_pkg::job_t pop_data
);

  mnv_pkg::job_t slots [2];
  logic wptr, rptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign pop_valid = fill != 2'd0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && pop_valid) rptr <= ~rptr;
      fill <= fill + 2'(push && !full) - 2'(pop && pop_valid);
    end
    if (push && !full) slots[wptr] <= push_data;
  end

  `MNV_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= 2'd2, "queue fill out of range")
  `MNV_ASSERT_NEXT(a_fill_empty, clk, rst, fill == 2'd0 && !push, fill == 2'd0,
                   "queue fill moved without push")
  `MNV_ASSERT_IMP(a_ptr_track, clk, rst, fill == 2'd0 || fill == 2'd2, wptr == rptr,
                  "queue pointers disagree with fill")

endmodule

@@ hdl/mnv_hash.sv @@
`include "mining_nonce_verifier_macros.svh"

module mnv_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  mnv_pkg::job_t      job,
  input  logic [255:0]       midstate,
  input  logic [95:0]        tail,
  output logic               res_valid,
  input  logic               res_stall,
  output mnv_pkg::out_req_t  res
);

  mnv_pkg::back_state_t state, state_next;
  logic [31:0] w [16];
  logic [31:0] w_load [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [255:0] base;
  logic [5:0] rnd;
  logic pass2;
  logic [2:0] trial;
  logic [31:0] dec, cand;
  logic [31:0] t1, t2, s0, s1, wn;
  logic [255:0] sum;
  logic load1, load2, step, adv;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign cand = dec + mnv_pkg::TRIAL_OFFSET[trial];
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign wn = w[0] + s0 + w[9] + s1;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + mnv_pkg::K_ROUND[rnd] + w[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign sum = {base[255:224] + a, base[223:192] + b, base[191:160] + c,
                base[159:128] + d, base[127:96] + e, base[95:64] + f,
                base[63:32] + g, base[31:0] + h};

  // Message block for the next compression: the header tail with the candidate,
  // or the first digest, each with its padding.
  always_comb begin
    for (int i = 0; i < 16; i++) w_load[i] = '0;
    if (load1) begin
      w_load[0] = tail[95:64];
      w_load[1] = tail[63:32];
      w_load[2] = tail[31:0];
      w_load[3] = cand;
      w_load[4] = 32'h8000_0000;
      w_load[15] = 32'd640;
    end else begin
      for (int i = 0; i < 8; i++) w_load[i] = sum[255-32*i -: 32];
      w_load[8] = 32'h8000_0000;
      w_load[15] = 32'd256;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnv_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
    if (job_pop) begin
      dec <= job.decoded;
      trial <= '0;
    end
    if (adv) trial <= trial + 1'b1;
    if (load1 || load2) begin
      rnd <= '0;
      pass2 <= load2;
      base <= load1 ? midstate : mnv_pkg::IV_STD;
      {a, b, c, d, e, f, g, h} <= load1 ? midstate : mnv_pkg::IV_STD;
      for (int i = 0; i < 16; i++) w[i] <= w_load[i];
    end else if (step) begin
      rnd <= rnd + 1'b1;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
  end

  always_comb begin
    state_next = state;
    job_pop = 1'b0;
    load1 = 1'b0;
    load2 = 1'b0;
    step = 1'b0;
    adv = 1'b0;
    res_valid = 1'b0;
    res.nonce_valid = 1'b0;
    res.nonce_value = dec;
    res.offset_choice = '0;
    unique case (state)
      mnv_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          state_next = mnv_pkg::BK_LOAD1;
        end
      end
      mnv_pkg::BK_LOAD1: begin
        load1 = 1'b1;
        state_next = mnv_pkg::BK_ROUND;
      end
      mnv_pkg::BK_ROUND: begin
        step = 1'b1;
        if (rnd == 6'd63) state_next = mnv_pkg::BK_FIN;
      end
      mnv_pkg::BK_FIN: begin
        if (!pass2) begin
          load2 = 1'b1;
          state_next = mnv_pkg::BK_ROUND;
        end else if (sum[31:0] == '0) begin
          state_next = mnv_pkg::BK_DONE;
        end else if (trial == 3'(mnv_pkg::NUM_TRIALS - 1)) begin
          state_next = mnv_pkg::BK_OUT;
        end else begin
          adv = 1'b1;
          state_next = mnv_pkg::BK_LOAD1;
        end
      end
      mnv_pkg::BK_DONE: begin
        res_valid = 1'b1;
        res.nonce_valid = 1'b1;
        res.nonce_value = cand;
        res.offset_choice = trial;
        if (!res_stall) state_next = mnv_pkg::BK_IDLE;
      end
      mnv_pkg::BK_OUT: begin
        res_valid = 1'b1;
        if (!res_stall) state_next = mnv_pkg::BK_IDLE;
      end
      default: state_next = mnv_pkg::BK_IDLE;
    endcase
  end

  `MNV_ASSERT_IMP(a_trial_bound, clk, rst, state != mnv_pkg::BK_IDLE,
                  trial < 3'(mnv_pkg::NUM_TRIALS), "trial index out of range")
  `MNV_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res),
                   "stalled result changed")
  `MNV_ASSERT_IMP(a_choice_ok, clk, rst, res_valid && !res.nonce_valid,
                  res.offset_choice == 3'd0, "error result with offset")

endmodule

@@ verif/nonce_check_monitor.sv @@
module nonce_check_monitor #(
  parameter int SEEN_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  mnv_pkg::in_req_t  req,
  input  logic              res_valid,
  input  logic              res_stall,
  input  mnv_pkg::out_req_t res,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output int                pending,
  output int                errors
);

  logic [63:0] midstate [4];
  logic [31:0] merkle_tail, stamp_word, bits_word;
  logic [31:0] seen_raw [SEEN_DEPTH];
  int          seen_n;
  mnv_pkg::out_req_t verdicts_due [$];
  int          err_n;

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(logic [255:0] hin, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] hw [8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    logic [255:0] hout;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int j = 0; j < 8; j++) hw[j] = hin[255 - 32*j -: 32];
    a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3];
    e = hw[4]; f = hw[5]; g = hw[6]; hh = hw[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + mnv_pkg::K_ROUND[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hout = {hw[0] + a, hw[1] + b, hw[2] + c, hw[3] + d,
            hw[4] + e, hw[5] + f, hw[6] + g, hw[7] + hh};
    return hout;
  endfunction

  // Double hash of the 80-byte header with this nonce; true when the last word is zero.
  function automatic bit nonce_hits(logic [31:0] nonce);
    logic [255:0] first, second;
    first = sha_compress({midstate[0], midstate[1], midstate[2], midstate[3]},
                         {merkle_tail, stamp_word, bits_word, nonce, 32'h8000_0000,
                          320'b0, 32'd640});
    second = sha_compress(mnv_pkg::IV_STD, {first, 32'h8000_0000, 192'b0, 32'd256});
    return second[31:0] == 32'd0;
  endfunction

  function automatic logic [31:0] unscramble(logic [31:0] raw);
    logic [23:0] rev;
    for (int b = 0; b < 3; b++)
      for (int i = 0; i < 8; i++) rev[b*8 + i] = raw[8 + b*8 + 7 - i];
    return {raw[7:0], rev[0], rev[1], rev[23:2]} - mnv_pkg::DECODE_BIAS;
  endfunction

  task automatic predict_verdict(mnv_pkg::in_req_t r);
    logic [31:0] dec, cand;
    mnv_pkg::out_req_t v;
    if (r.batch_start) seen_n = 0;
    for (int i = 0; i < seen_n; i++)
      if (seen_raw[i] == r.raw_nonce) return;
    if (seen_n < SEEN_DEPTH) begin
      seen_raw[seen_n] = r.raw_nonce;
      seen_n++;
    end
    dec = unscramble(r.raw_nonce);
    v.nonce_valid = 1'b0;
    v.nonce_value = dec;
    v.offset_choice = 3'd0;
    for (int t = 0; t < mnv_pkg::NUM_TRIALS; t++) begin
      cand = dec + mnv_pkg::TRIAL_OFFSET[t];
      if (nonce_hits(cand)) begin
        v.nonce_valid = 1'b1;
        v.nonce_value = cand;
        v.offset_choice = 3'(t);
        break;
      end
    end
    verdicts_due.push_back(v);
  endtask

  always @(posedge clk) begin
    mnv_pkg::out_req_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) midstate[i] = '0;
      merkle_tail = '0;
      stamp_word = '0;
      bits_word = '0;
      seen_n = 0;
      verdicts_due.delete();
      err_n = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: valid=%0d value=%h offset=%0d",
                 res.nonce_valid, res.nonce_value, res.offset_choice);
          err_n++;
        end else begin
          want = verdicts_due.pop_front();
          if (res.nonce_valid !== want.nonce_valid) begin
            $error("nonce_valid: expected %0d, got %0d", want.nonce_valid, res.nonce_valid);
            err_n++;
          end
          if (res.nonce_value !== want.nonce_value) begin
            $error("nonce_value: expected %h, got %h", want.nonce_value, res.nonce_value);
            err_n++;
          end
          if (res.offset_choice !== want.offset_choice) begin
            $error("offset_choice: expected %0d, got %0d",
                   want.offset_choice, res.offset_choice);
            err_n++;
          end
        end
      end
      if (req_valid && !req_stall) predict_verdict(req);
      if (cfg_we) begin
        case (cfg_index)
          mnv_pkg::REG_MID01:  midstate[0] = cfg_data;
          mnv_pkg::REG_MID23:  midstate[1] = cfg_data;
          mnv_pkg::REG_MID45:  midstate[2] = cfg_data;
          mnv_pkg::REG_MID67:  midstate[3] = cfg_data;
          mnv_pkg::REG_MERKLE: merkle_tail = cfg_data[31:0];
          mnv_pkg::REG_TIME:   stamp_word = cfg_data[31:0];
          mnv_pkg::REG_BITS:   bits_word = cfg_data[31:0];
          default: ;
        endcase
      end
    end
    pending <= verdicts_due.size();
    errors <= err_n;
  end
endmodule

@@ verif/testbench.sv @@
module testbench;

  // An index outside the register map; a write to it must change nothing.
  localparam logic [3:0] REG_NONE = 4'd15;
  // Cycles with no request or result moving before the run is declared hung.
  // It allows for the slowest correct request, plus the long receiver hold.
  localparam int HANG_LIMIT = 40000;
  // Settling time after the last result: a duplicate still needs its scan.
  localparam int SETTLE = 1200;
  localparam int HOLD_CYCLES = 4000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  mnv_pkg::in_req_t  req;
  logic        res_valid;
  logic        res_stall;
  mnv_pkg::out_req_t res;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;
  int          pending;
  int          errors;
  bit          hold_request;
  int          idle_cycles;
  logic [31:0] batch_log [$];
  int          sent;

  mining_nonce_verifier dut (
    .clk, .rst, .req_valid, .req_stall, .req,
    .res_valid, .res_stall, .res, .cfg_we, .cfg_index, .cfg_data
  );

  nonce_check_monitor checker_i (
    .clk, .rst, .req_valid, .req_stall, .req,
    .res_valid, .res_stall, .res, .cfg_we, .cfg_index, .cfg_data,
    .pending, .errors
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 150);
  endfunction

  // The receiver stalls at random; when asked, it holds off for a long stretch so
  // that the two-entry queue fills and the front pushes back on new requests.
  initial begin
    int n;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      n = pick_gap();
      if (n == 0) begin
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog: anything moving on either channel resets the count.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one request and holds it until it is taken. With no gap following,
  // valid stays high into the next request.
  task automatic send_nonce(logic [31:0] raw, logic first_of_batch, bit no_gap = 0);
    int gap;
    req_valid <= 1'b1;
    req <= '{raw_nonce: raw, batch_start: first_of_batch};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_settings(logic [63:0] m01, logic [63:0] m23, logic [63:0] m45,
                                logic [63:0] m67, logic [31:0] mk, logic [31:0] tm,
                                logic [31:0] bt);
    logic [3:0]  idx [8];
    logic [63:0] val [8];
    idx = '{mnv_pkg::REG_MID01, mnv_pkg::REG_MID23, mnv_pkg::REG_MID45,
            mnv_pkg::REG_MID67, mnv_pkg::REG_MERKLE, mnv_pkg::REG_TIME,
            mnv_pkg::REG_BITS, REG_NONE};
    val = '{m01, m23, m45, m67, {32'h0, mk}, {32'h0, tm}, {32'h0, bt},
            64'hFFFF_FFFF_FFFF_FFFF};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A batch of fresh nonces with some duplicates mixed in; duplicates draw no result.
  task automatic random_batch(int len);
    logic [31:0] raw;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) < 25)
        raw = batch_log[$urandom_range(0, batch_log.size() - 1)];
      else
        raw = $urandom();
      if (i == 0) batch_log.delete();
      batch_log.push_back(raw);
      send_nonce(raw, i == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = mnv_pkg::REG_MID01;
    cfg_data = '0;
    hold_request = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the all-zero settings after reset: field extremes,
    // single bits, duplicates, and a new batch that forgets the earlier ones.
    send_nonce(32'h0000_0000, 1'b1);
    send_nonce(32'hFFFF_FFFF, 1'b0);
    send_nonce(32'h0000_0001, 1'b0);
    send_nonce(32'h8000_0000, 1'b0);
    send_nonce(32'hAAAA_AAAA, 1'b0);
    send_nonce(32'h5555_5555, 1'b0);
    send_nonce(32'h0000_00FF, 1'b0);
    send_nonce(32'hFF00_0000, 1'b0);
    send_nonce(32'h0000_0100, 1'b0);
    send_nonce(32'h0080_0004, 1'b0);
    send_nonce(32'h0000_0000, 1'b0);
    send_nonce(32'hFFFF_FFFF, 1'b0);
    send_nonce(32'h0000_0000, 1'b1);
    send_nonce(32'h0000_0000, 1'b0);
    drain();

    // Every register at its top value.
    write_settings('1, '1, '1, '1, '1, '1, '1);
    send_nonce(32'h1234_5678, 1'b1);
    send_nonce(32'hFFFF_FFFF, 1'b0);
    send_nonce(32'h0000_0000, 1'b0);
    send_nonce(32'h1234_5678, 1'b0);

    // Long receiver hold while requests arrive back to back, then the sender
    // waits for every result.
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_nonce($urandom(), 1'b0, 1);
    drain();

    // Saturate the seen store: more distinct nonces than it holds, then repeats of the
    // first and last stored ones (suppressed) and of later ones (not stored, so reported again).
    write_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, {$urandom(), $urandom()},
                   $urandom(), $urandom(), $urandom());
    batch_log.delete();
    for (int i = 0; i < 140; i++) begin
      batch_log.push_back(32'h0100_0000 + 32'(i) * 32'h0001_0203);
      send_nonce(batch_log[i], i == 0);
    end
    send_nonce(batch_log[0], 1'b0);
    send_nonce(batch_log[127], 1'b0);
    send_nonce(batch_log[128], 1'b0);
    send_nonce(batch_log[139], 1'b0);
    drain();

    // Random batches across several random settings.
    while (sent < 580) begin
      write_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
                     {$urandom(), $urandom()}, {$urandom(), $urandom()},
                     $urandom(), $urandom(), $urandom());
      for (int b = 0; b < 8 && sent < 580; b++) begin
        if ($urandom_range(0, 9) == 0) send_nonce($urandom(), $urandom_range(0, 1));
        random_batch($urandom_range(1, 20));
      end
      drain();
    end

    // Back to the bottom extreme before finishing.
    write_settings('0, '0, '0, '0, '0, '0, '0);
    random_batch(10);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
